// ===== rtl/cwr_pkg.sv =====
// ----------------------------------------------------------------------------
// cwr_pkg
// Shared types and constants of the character-to-word stream replacer.
// ----------------------------------------------------------------------------
package cwr_pkg;

   localparam int PAL_MAX  = 8;                                   // longest word
   localparam int LEN_W    = 4;                                   // word_len field
   localparam int IDX_W    = (PAL_MAX > 1) ? $clog2(PAL_MAX) : 1; // byte index
   localparam int CHAR_W   = 8;
   localparam int WORD_W   = 64;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 64;

   typedef enum logic [1:0] {
      REG_TARGET_CHAR = 2'd0,
      REG_WORD_LEN    = 2'd1,
      REG_WORD_BYTES  = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [CHAR_W-1:0] target_char;
      logic [LEN_W-1:0]  word_len;
      logic [WORD_W-1:0] word_bytes;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic out_load;   // load the output register
      logic sel_word;   // load a word byte instead of the input byte
      logic idx_start;  // emit word byte 0, index moves to 1
      logic idx_next;   // emit word byte at index, index advances
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // output register empty or being taken
      logic match;      // input byte equals target
      logic len_zero;   // word is empty
      logic len_one;    // word has a single byte
      logic idx_last;   // index points at the last word byte
   } sts_type;

endpackage

// ===== rtl/cwr_csr.sv =====
// ----------------------------------------------------------------------------
// cwr_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module cwr_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [cwr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [cwr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [cwr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                      csr_pready,
   output cwr_pkg::cfg_type          cfg
);
   import cwr_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        wr_en;
   reg_idx_type reg_idx;
   logic        addr_hi;

   assign reg_idx    = reg_idx_type'(csr_paddr[4:3]);
   assign addr_hi    = (csr_paddr[4:3] == 2'd3);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en && !addr_hi) begin
         unique case (reg_idx)
            REG_TARGET_CHAR: cfg_in.target_char = csr_pwdata[CHAR_W-1:0];
            REG_WORD_LEN:    cfg_in.word_len    = csr_pwdata[LEN_W-1:0];
            REG_WORD_BYTES:  cfg_in.word_bytes  = csr_pwdata[WORD_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (!addr_hi) begin
         unique case (reg_idx)
            REG_TARGET_CHAR: csr_prdata = CSR_DW'(cfg_ff.target_char);
            REG_WORD_LEN:    csr_prdata = CSR_DW'(cfg_ff.word_len);
            REG_WORD_BYTES:  csr_prdata = CSR_DW'(cfg_ff.word_bytes);
            default:         csr_prdata = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/cwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cwr_ctrl
// Controller: takes input items and steps through a replacement word.
// ----------------------------------------------------------------------------
module cwr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cwr_pkg::sts_type sts,
   output cwr_pkg::cmd_type cmd
);
   import cwr_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid & req_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = sts.out_free;
            if (accept) begin
               if (!sts.match) begin
                  cmd.out_load = 1'b1;
               end else if (!sts.len_zero) begin
                  cmd.out_load  = 1'b1;
                  cmd.sel_word  = 1'b1;
                  cmd.idx_start = 1'b1;
                  if (!sts.len_one) begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            // hold input until the word's last byte is loaded
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.sel_word = 1'b1;
               cmd.idx_next = 1'b1;
               if (sts.idx_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/cwr_datapath.sv =====
// ----------------------------------------------------------------------------
// cwr_datapath
// Byte index, byte selection and the output register.
// ----------------------------------------------------------------------------
module cwr_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  cwr_pkg::cfg_type           cfg,
   input  logic [cwr_pkg::CHAR_W-1:0] req_char_in,
   input  cwr_pkg::cmd_type           cmd,
   output cwr_pkg::sts_type           sts,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cwr_pkg::CHAR_W-1:0] rsp_char_out,
   output logic                       rsp_run_last
);
   import cwr_pkg::*;

   logic [IDX_W-1:0]  idx_ff,   idx_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff,  char_in;
   logic              last_ff,  last_in;
   logic [LEN_W-1:0]  eff_len;
   logic [IDX_W-1:0]  sel_idx;
   logic [CHAR_W-1:0] word_byte;
   logic              word_last;

   // saturate the length to the word buffer size
   assign eff_len = (cfg.word_len > LEN_W'(PAL_MAX)) ? LEN_W'(PAL_MAX) : cfg.word_len;

   assign sel_idx   = cmd.idx_start ? '0 : idx_ff;
   assign word_byte = cfg.word_bytes[CHAR_W*sel_idx +: CHAR_W];
   assign word_last = (LEN_W'(sel_idx) + LEN_W'(1)) == eff_len;

   assign sts.out_free = ~valid_ff | rsp_ready;
   assign sts.match    = (req_char_in == cfg.target_char);
   assign sts.len_zero = (eff_len == '0);
   assign sts.len_one  = (eff_len == LEN_W'(1));
   assign sts.idx_last = (LEN_W'(idx_ff) + LEN_W'(1)) == eff_len;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.idx_start || cmd.idx_next) begin
         idx_in = sel_idx + IDX_W'(1);
      end
      if (cmd.out_load) begin
         valid_in = 1'b1;
         char_in  = cmd.sel_word ? word_byte : req_char_in;
         last_in  = cmd.sel_word ? word_last : 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         char_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         char_ff  <= char_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_char_out = char_ff;
   assign rsp_run_last = last_ff;

endmodule

// ===== rtl/char_to_word_stream_replacer.sv =====
// ----------------------------------------------------------------------------
// char_to_word_stream_replacer
// Replaces each target byte of a text stream by a configured word.
// ----------------------------------------------------------------------------
//  channel | ports                         | moves
//  --------+-------------------------------+-------------------------------
//  req     | req_valid/ready, req_char_in  | one input byte per item
//  rsp     | rsp_valid/ready, rsp_char_out | one output byte, run_last mark
//  csr     | csr_psel..csr_pready (64 bit) | target, length, word at 0/8/16
//
//  A passed byte shows on rsp the cycle after accept.
//  A matched byte is replaced by a word of N bytes: the word is walked
//  one byte a cycle while rsp does not stall, through the single output
//  register, input held. An empty word drops the matched byte.
//  Reset is synchronous and clears all registers to zero.
//  A stall on rsp holds the output register and, through it, the input.
// ----------------------------------------------------------------------------
module char_to_word_stream_replacer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cwr_pkg::CHAR_W-1:0] req_char_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cwr_pkg::CHAR_W-1:0] rsp_char_out,
   output logic                       rsp_run_last,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [cwr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [cwr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [cwr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import cwr_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   cwr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cwr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cwr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_char_in  (req_char_in),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_run_last (rsp_run_last)
   );

   // never overwrite an item that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register overwritten");

   // input is held while a word is being walked
   a_hold_in_word: assert property (@(posedge clock) disable iff (reset)
      cmd.idx_next |-> !req_ready)
      else $error("input taken during word");

   // a non-matching byte passes as a single marked item
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !sts.match |=>
         rsp_valid && rsp_run_last && (rsp_char_out == $past(req_char_in)))
      else $error("pass-through byte lost or altered");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: character-to-word replacer regression
// Drives byte items through the replacer, rewrites the target, word length
// and word registers between idle phases, and checks every output byte and
// its run mark against an in-bench expansion of the input stream.
// ----------------------------------------------------------------------------
module tb_top;
   import cwr_pkg::*;

   localparam int          CLK_HALF     = 6;
   localparam int          RESET_CYCLES = 7;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          SEGMENTS     = 5;
   localparam int          SEG_ITEMS    = 29;
   localparam int          TARGET_PCT   = 35;
   localparam logic [1:0]  REG_SPARE    = 2'd3;   // no register behind this index

   typedef enum logic {ROW_CHAR, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [1:0]         idx;
      logic [CSR_DW-1:0]  value;
      logic [CHAR_W-1:0]  ch;
      logic               typed;
      logic [LEN_W-1:0]   exp_n;
      logic [WORD_W-1:0]  exp_bytes;
   } plan_row_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } out_byte_type;

   localparam int DIR_ROWS = 33;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_in;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CHAR_W-1:0]   rsp_char_out;
   logic                rsp_run_last;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // shadow copy of the registers
   logic [CHAR_W-1:0]   target_q;
   logic [LEN_W-1:0]    word_len_q;
   logic [WORD_W-1:0]   word_q;

   out_byte_type        expected_out[$];
   out_byte_type        head_byte;
   plan_row_type        dir_plan [0:DIR_ROWS-1];
   int                  mismatch_count = 0;
   int                  cycle_count    = 0;
   int                  send_idle_pct  = 25;
   int                  recv_idle_pct  = 78;

   char_to_word_stream_replacer DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_out (rsp_char_out),
      .rsp_run_last (rsp_run_last),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h (cycle %0d)",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // queue n bytes of a packed word, first byte in the low bits
   task automatic push_run(input int n, input logic [WORD_W-1:0] bytes);
      for (int k = 0; k < n; k++)
         expected_out.push_back('{ch: bytes[8*k +: 8], last: (k == n - 1)});
   endtask

   task automatic expand_char(input logic [CHAR_W-1:0] ch);
      int n;
      n = (word_len_q > PAL_MAX) ? PAL_MAX : int'(word_len_q);
      if (ch != target_q)
         push_run(1, WORD_W'(ch));
      else
         push_run(n, word_q);
   endtask

   function automatic plan_row_type ch_row(input logic [CHAR_W-1:0] ch);
      return '{kind: ROW_CHAR, idx: '0, value: '0, ch: ch, typed: 1'b0,
               exp_n: '0, exp_bytes: '0};
   endfunction

   function automatic plan_row_type typed_row(input logic [CHAR_W-1:0] ch,
                                              input logic [LEN_W-1:0] n,
                                              input logic [WORD_W-1:0] bytes);
      return '{kind: ROW_CHAR, idx: '0, value: '0, ch: ch, typed: 1'b1,
               exp_n: n, exp_bytes: bytes};
   endfunction

   function automatic plan_row_type wr_row(input logic [1:0] idx,
                                           input logic [CSR_DW-1:0] value);
      return '{kind: ROW_WRITE, idx: idx, value: value, ch: '0, typed: 1'b0,
               exp_n: '0, exp_bytes: '0};
   endfunction

   // drive one item; the expected bytes are queued before it can be taken
   task automatic push_char(input logic [CHAR_W-1:0] ch, input logic typed,
                            input logic [LEN_W-1:0] exp_n,
                            input logic [WORD_W-1:0] exp_bytes);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= ch;
      if (typed)
         push_run(int'(exp_n), exp_bytes);
      else
         expand_char(ch);
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid, let every expected byte arrive, then let the block settle
   task automatic wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_out.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TARGET_CHAR: target_q   = value[CHAR_W-1:0];
         REG_WORD_LEN:    word_len_q = value[LEN_W-1:0];
         REG_WORD_BYTES:  word_q     = value[WORD_W-1:0];
         default: ;
      endcase
      want = {CSR_DW{1'b0}};
      case (idx)
         REG_TARGET_CHAR: want = CSR_DW'(target_q);
         REG_WORD_LEN:    want = CSR_DW'(word_len_q);
         REG_WORD_BYTES:  want = CSR_DW'(word_q);
         default: ;
      endcase
      // read back what was written, except at the unused index
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_psel    <= (idx != REG_SPARE);
      if (idx != REG_SPARE) begin
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== want)
            report_mismatch("register read", csr_prdata, want);
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   task automatic random_segment;
      int r;
      logic [CHAR_W-1:0] ch;
      wait_drained();
      r = $urandom_range(9);
      csr_write(REG_TARGET_CHAR, CSR_DW'($urandom_range(255)));
      // one segment in ten runs with a word length above the bound
      csr_write(REG_WORD_LEN, CSR_DW'((r == 9) ? $urandom_range(15, 9)
                                               : $urandom_range(8)));
      csr_write(REG_WORD_BYTES, {$urandom, $urandom});
      for (int i = 0; i < SEG_ITEMS; i++) begin
         ch = ($urandom_range(99) < TARGET_PCT) ? target_q : CHAR_W'($urandom_range(255));
         push_char(ch, 1'b0, '0, '0);
      end
   endtask

   // accept side: advance the expected queue on every taken output byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            report_mismatch("unexpected output byte", 64'(rsp_char_out), 64'h0);
         end else begin
            head_byte = expected_out.pop_front();
            if (rsp_char_out !== head_byte.ch)
               report_mismatch("char_out", 64'(rsp_char_out), 64'(head_byte.ch));
            if (rsp_run_last !== head_byte.last)
               report_mismatch("run_last", 64'(rsp_run_last), 64'(head_byte.last));
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_char_in = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      target_q    = '0;
      word_len_q  = '0;
      word_q      = '0;

      dir_plan = '{
         typed_row(8'h00, 4'd0, 64'h0),            // reset word is empty: drop
         typed_row(8'hFF, 4'd1, 64'hFF),
         ch_row(8'h5A),
         wr_row(REG_TARGET_CHAR, 64'hFF),
         wr_row(REG_WORD_LEN, 64'd8),
         wr_row(REG_WORD_BYTES, 64'h00FF_A55A_0180_7E00),  // zeros inside the word
         ch_row(8'hFF),
         typed_row(8'h00, 4'd1, 64'h00),
         typed_row(8'hFE, 4'd1, 64'hFE),
         wr_row(REG_WORD_LEN, 64'd15),             // saturates to the longest word
         ch_row(8'hFF),
         ch_row(8'hFF),
         wr_row(REG_WORD_LEN, 64'd9),
         ch_row(8'hFF),
         wr_row(REG_WORD_LEN, 64'd1),
         ch_row(8'hFF),
         ch_row(8'h7F),
         wr_row(REG_TARGET_CHAR, 64'h00),
         wr_row(REG_WORD_LEN, 64'd0),
         typed_row(8'h00, 4'd0, 64'h0),
         typed_row(8'h00, 4'd0, 64'h0),
         typed_row(8'h01, 4'd1, 64'h01),
         wr_row(REG_SPARE, {CSR_DW{1'b1}}),        // must leave every register alone
         typed_row(8'h00, 4'd0, 64'h0),
         typed_row(8'h80, 4'd1, 64'h80),
         wr_row(REG_WORD_BYTES, {CSR_DW{1'b1}}),
         wr_row(REG_WORD_LEN, 64'd2),
         ch_row(8'h00),
         ch_row(8'hFF),
         wr_row(REG_TARGET_CHAR, 64'h80),
         wr_row(REG_WORD_LEN, 64'd8),
         ch_row(8'h80),
         ch_row(8'h00)
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_plan[i]) begin
         if (dir_plan[i].kind == ROW_WRITE) begin
            wait_drained();
            csr_write(dir_plan[i].idx, dir_plan[i].value);
         end else begin
            push_char(dir_plan[i].ch, dir_plan[i].typed, dir_plan[i].exp_n,
                      dir_plan[i].exp_bytes);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 25; recv_idle_pct = 78; end
            1: begin send_idle_pct = 78; recv_idle_pct = 25; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int s = 0; s < SEGMENTS; s++)
            random_segment();
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cwr_pkg.sv
rtl/cwr_csr.sv
rtl/cwr_ctrl.sv
rtl/cwr_datapath.sv
rtl/char_to_word_stream_replacer.sv
verif/tb_top.sv
